// ----- hw/rtl/sac_pkg.sv -----
`default_nettype none
package sac_pkg;

	// Fixed widths of the stream words and of the configuration port.
	localparam int unsigned AddrInW  = 32;
	localparam int unsigned SDataW   = 32;
	localparam int unsigned MDataW   = 24;
	localparam int unsigned CfgIdxW  = 2;
	localparam int unsigned CfgDataW = 4;
	localparam int unsigned OutWayW  = 3;
	localparam int unsigned OutProbW = 4;
	localparam int unsigned OutSetW  = 10;

	// Register indexes.
	localparam logic [CfgIdxW-1:0] REG_MODE   = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_OFFSET = 2'd1;
	localparam logic [CfgIdxW-1:0] REG_SETS   = 2'd2;
	localparam logic [CfgIdxW-1:0] REG_WAYS   = 2'd3;

	// Lookup modes.
	localparam logic [1:0] MODE_CONV    = 2'd0;
	localparam logic [1:0] MODE_PREDICT = 2'd1;
	localparam logic [1:0] MODE_HALT    = 2'd2;

	// Largest block offset that is honoured.
	localparam logic [3:0] OFFSET_MAX = 4'd12;

	// Result word as it leaves the block, highest field first.
	typedef struct packed {
		logic [MDataW-OutSetW-OutProbW-OutWayW-3:0] pad;
		logic [OutSetW-1:0]  set_index;
		logic [OutProbW-1:0] ways_probed;
		logic                predicted_hit;
		logic [OutWayW-1:0]  hit_way;
		logic                hit;
	} result_t;

	// Register file contents shared by the front and the back.
	typedef struct packed {
		logic [1:0] mode;
		logic [3:0] offset_bits;
		logic [3:0] set_bits;
		logic [3:0] ways_in_use;
	} cfg_t;

endpackage
`default_nettype wire

// ----- hw/rtl/sac_front.sv -----
`default_nettype none
module sac_front
	import sac_pkg::*;
#(
	parameter int unsigned MAX_SETS   = 1024,
	parameter int unsigned ADDR_WIDTH = 32
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire cfg_t                  cfg,
	input  wire logic                  init_done,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [SDataW-1:0]     s_tdata,
	output logic                       q_valid,
	input  wire logic                  q_pop,
	output logic [((MAX_SETS > 1) ? $clog2(MAX_SETS) : 1)-1:0] q_set,
	output logic [ADDR_WIDTH-1:0]      q_tag
);

	localparam int unsigned SET_W    = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
	localparam int unsigned MSB_BITS = $clog2(MAX_SETS + 1) - 1;

	logic [ADDR_WIDTH-1:0] addr;
	logic [3:0]            ob;
	logic [3:0]            sb;
	logic [4:0]            tsh;
	logic [ADDR_WIDTH-1:0] set_mask;
	logic [ADDR_WIDTH-1:0] set_full;
	logic [SET_W-1:0]      set_new;
	logic [ADDR_WIDTH-1:0] tag_new;
	logic                  push;

	logic [SET_W-1:0]      set_q [2];
	logic [ADDR_WIDTH-1:0] tag_q [2];
	logic                  wr_ptr_q;
	logic                  rd_ptr_q;
	logic [1:0]            count_q;

	assign addr     = ADDR_WIDTH'(s_tdata);
	assign ob       = (cfg.offset_bits > OFFSET_MAX) ? OFFSET_MAX : cfg.offset_bits;
	assign sb       = (cfg.set_bits > 4'(MSB_BITS)) ? 4'(MSB_BITS) : cfg.set_bits;
	assign tsh      = {1'b0, ob} + {1'b0, sb};
	assign set_mask = (ADDR_WIDTH'(1) << sb) - ADDR_WIDTH'(1);
	assign set_full = (addr >> ob) & set_mask;
	assign set_new  = set_full[SET_W-1:0];
	assign tag_new  = addr >> tsh;

	assign s_tready = init_done && (count_q != 2'd2);
	assign push     = s_tvalid && s_tready;
	assign q_valid  = (count_q != 2'd0);
	assign q_set    = set_q[rd_ptr_q];
	assign q_tag    = tag_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			set_q[wr_ptr_q] <= set_new;
			tag_q[wr_ptr_q] <= tag_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (q_pop)
				rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

`ifndef NO_ASSERTIONS
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid) else $error("pop from an empty queue");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3) else $error("queue count out of range");
	a_no_push_before_init: assert property (@(posedge clk) disable iff (!arst_n)
		!init_done |-> !push) else $error("word taken during clearing pass");
`endif

endmodule
`default_nettype wire

// ----- hw/rtl/sac_back.sv -----
`default_nettype none
module sac_back
	import sac_pkg::*;
#(
	parameter int unsigned MAX_WAYS   = 8,
	parameter int unsigned MAX_SETS   = 1024,
	parameter int unsigned ADDR_WIDTH = 32,
	parameter int unsigned HALT_BITS  = 4
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire cfg_t                  cfg,
	output logic                       init_done,
	input  wire logic                  q_valid,
	output logic                       q_pop,
	input  wire logic [((MAX_SETS > 1) ? $clog2(MAX_SETS) : 1)-1:0] q_set,
	input  wire logic [ADDR_WIDTH-1:0] q_tag,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [MDataW-1:0]          m_tdata
);

	localparam int unsigned SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
	localparam int unsigned WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int unsigned CNT_W = $clog2(MAX_WAYS + 1);

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_EVAL  = 2'd2;

	typedef logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0] tag_row_t;
	typedef logic [MAX_WAYS-1:0][WAY_W-1:0]      rank_row_t;
	typedef logic [MAX_WAYS-1:0][HALT_BITS-1:0]  halt_row_t;

	// Tag store, one row per set.
	logic [MAX_WAYS-1:0] valid_mem [MAX_SETS];
	tag_row_t            tag_mem   [MAX_SETS];
	rank_row_t           rank_mem  [MAX_SETS];
	halt_row_t           halt_mem  [MAX_SETS];
	logic [WAY_W-1:0]    mru_mem   [MAX_SETS];

	logic [1:0]          st_q;
	logic [SET_W-1:0]    clr_q;
	logic [SET_W-1:0]    set_s1;
	logic [ADDR_WIDTH-1:0] tag_s1;
	logic [MAX_WAYS-1:0] rv_s1;
	tag_row_t            rt_s1;
	rank_row_t           rr_s1;
	halt_row_t           rh_s1;
	logic [WAY_W-1:0]    rm_s1;
	logic                out_valid_q;
	result_t             out_q;

	logic [CNT_W-1:0]    ways;
	logic [HALT_BITS-1:0] htag;
	logic [MAX_WAYS-1:0] match;
	logic [MAX_WAYS-1:0] hmatch;
	logic                hit;
	logic                pred;
	logic [WAY_W-1:0]    w;
	logic [CNT_W-1:0]    probed;
	logic                fire;
	logic                mem_we;
	logic [SET_W-1:0]    mem_addr;
	logic [MAX_WAYS-1:0] new_valid;
	tag_row_t            new_tag;
	rank_row_t           new_rank;
	halt_row_t           new_halt;
	logic [WAY_W-1:0]    new_mru;
	result_t             res;

	assign ways = (cfg.ways_in_use == 4'd0) ? CNT_W'(1) :
		((32'(cfg.ways_in_use) > MAX_WAYS) ? CNT_W'(MAX_WAYS) : CNT_W'(cfg.ways_in_use));
	assign htag = tag_s1[HALT_BITS-1:0];

	always_comb begin
		for (int i = 0; i < MAX_WAYS; i++) begin
			match[i]  = (CNT_W'(i) < ways) && rv_s1[i] && (rt_s1[i] == tag_s1);
			hmatch[i] = (CNT_W'(i) < ways) && (rh_s1[i] == htag);
		end
	end

	// Hit search in the order of the selected mode, then victim choice on a miss.
	always_comb begin
		logic [WAY_W-1:0] p;
		logic [WAY_W:0]   q;
		logic [MAX_WAYS-1:0] cand;
		hit    = 1'b0;
		pred   = 1'b0;
		w      = '0;
		probed = ways;
		p      = '0;
		q      = '0;
		cand   = match;
		case (cfg.mode)
			MODE_PREDICT: begin
				p = (CNT_W'(rm_s1) < ways) ? rm_s1 : '0;
				if (match[p]) begin
					hit    = 1'b1;
					pred   = 1'b1;
					w      = p;
					probed = CNT_W'(1);
				end else begin
					for (int k = 1; k < MAX_WAYS; k++) begin
						q = {1'b0, p} + (WAY_W + 1)'(k);
						if ((WAY_W + 1)'(q) >= (WAY_W + 1)'(ways))
							q = q - (WAY_W + 1)'(ways);
						if (!hit && (CNT_W'(k) < ways) && match[q[WAY_W-1:0]]) begin
							hit = 1'b1;
							w   = q[WAY_W-1:0];
						end
					end
				end
			end
			MODE_HALT: begin
				cand   = match & hmatch;
				probed = CNT_W'($countones(hmatch));
				for (int i = MAX_WAYS - 1; i >= 0; i--)
					if (cand[i]) begin
						hit = 1'b1;
						w   = WAY_W'(i);
					end
			end
			default: begin
				for (int i = MAX_WAYS - 1; i >= 0; i--)
					if (cand[i]) begin
						hit = 1'b1;
						w   = WAY_W'(i);
					end
			end
		endcase
		if (!hit) begin
			w = '0;
			for (int i = 1; i < MAX_WAYS; i++)
				if ((CNT_W'(i) < ways) && (rr_s1[i] < rr_s1[w]))
					w = WAY_W'(i);
		end
	end

	// Row write-back: fill on a miss, rank ageing and the new MRU way.
	always_comb begin
		new_valid = rv_s1;
		new_tag   = rt_s1;
		new_halt  = rh_s1;
		new_rank  = rr_s1;
		new_mru   = w;
		if (!hit) begin
			new_valid[w] = 1'b1;
			new_tag[w]   = tag_s1;
			new_halt[w]  = htag;
		end
		for (int i = 0; i < MAX_WAYS; i++)
			if ((CNT_W'(i) < ways) && (WAY_W'(i) != w) && (rr_s1[i] > rr_s1[w]))
				new_rank[i] = rr_s1[i] - WAY_W'(1);
		new_rank[w] = WAY_W'(ways - CNT_W'(1));
	end

	always_comb begin
		res               = '0;
		res.hit           = hit;
		res.hit_way       = OutWayW'(w);
		res.predicted_hit = pred;
		res.ways_probed   = OutProbW'(probed);
		res.set_index     = OutSetW'(set_s1);
	end

	assign fire      = (st_q == ST_EVAL) && (!out_valid_q || m_tready);
	assign q_pop     = (st_q == ST_IDLE) && q_valid;
	assign init_done = (st_q != ST_CLEAR);
	assign mem_we    = (st_q == ST_CLEAR) || fire;
	assign mem_addr  = (st_q == ST_CLEAR) ? clr_q : set_s1;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			valid_mem[mem_addr] <= (st_q == ST_CLEAR) ? '0 : new_valid;
			tag_mem[mem_addr]   <= (st_q == ST_CLEAR) ? '0 : new_tag;
			rank_mem[mem_addr]  <= (st_q == ST_CLEAR) ? '0 : new_rank;
			halt_mem[mem_addr]  <= (st_q == ST_CLEAR) ? '0 : new_halt;
			mru_mem[mem_addr]   <= (st_q == ST_CLEAR) ? '0 : new_mru;
		end
		if (q_pop) begin
			rv_s1  <= valid_mem[q_set];
			rt_s1  <= tag_mem[q_set];
			rr_s1  <= rank_mem[q_set];
			rh_s1  <= halt_mem[q_set];
			rm_s1  <= mru_mem[q_set];
			set_s1 <= q_set;
			tag_s1 <= q_tag;
		end
		if (fire)
			out_q <= res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
			case (st_q)
				ST_CLEAR: begin
					clr_q <= clr_q + SET_W'(1);
					if (clr_q == SET_W'(MAX_SETS - 1))
						st_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (q_pop)
						st_q <= ST_EVAL;
				end
				ST_EVAL: begin
					if (fire)
						st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_CLEAR) |-> !q_pop) else $error("queue popped during clearing pass");
	a_eval_then_idle: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> (st_q == ST_IDLE)) else $error("back did not return to idle");
	a_pred_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && pred) |-> (cfg.mode == MODE_PREDICT && hit))
		else $error("predicted hit outside prediction mode");
	a_probe_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fire |-> (probed <= ways)) else $error("more ways probed than in use");
`endif

endmodule
`default_nettype wire

// ----- hw/rtl/set_assoc_cache_tag_lru_way_predict_unit.sv -----
`default_nettype none
// Channel   Dir  Word fields (lowest bit first)
// s_axis    in   address[31:0]
// m_axis    out  hit, hit_way[2:0], predicted_hit, ways_probed[3:0], set_index[9:0]
// cfg       in   cfg_index selects mode, offset_bits, set_bits, ways_in_use
//
// In the back end each address first has its set row read from the tag store into
// registers, then the hit is resolved and the updated row is written back.
// The front splits the address and holds up to two words in a queue, so until it is
// full it keeps taking words while the back end works or a result waits on m_tready.
// After reset the back end clears the tag store one set per cycle, all MAX_SETS
// sets, and s_tready stays low until that pass is complete.
// Configuration is written through cfg_we and takes effect at once.
module set_assoc_cache_tag_lru_way_predict_unit
	import sac_pkg::*;
#(
	parameter int unsigned MAX_WAYS   = 8,
	parameter int unsigned MAX_SETS   = 1024,
	parameter int unsigned ADDR_WIDTH = 32,
	parameter int unsigned HALT_BITS  = 4
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [CfgIdxW-1:0]  cfg_index,
	input  wire logic [CfgDataW-1:0] cfg_data,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	input  wire logic [SDataW-1:0]   s_tdata,  // address[31:0]
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	output logic [MDataW-1:0]        m_tdata   // hit, hit_way, predicted_hit,
	                                           // ways_probed, set_index, zero pad
);

	localparam int unsigned SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;

	cfg_t                  cfg_q;
	logic                  init_done;
	logic                  q_valid;
	logic                  q_pop;
	logic [SET_W-1:0]      q_set;
	logic [ADDR_WIDTH-1:0] q_tag;

	// Register file; the reset values give a 64-set, 4-way cache of 64-byte lines.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode        <= MODE_CONV;
			cfg_q.offset_bits <= 4'd6;
			cfg_q.set_bits    <= 4'd6;
			cfg_q.ways_in_use <= 4'd4;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MODE:   cfg_q.mode        <= cfg_data[1:0];
				REG_OFFSET: cfg_q.offset_bits <= cfg_data;
				REG_SETS:   cfg_q.set_bits    <= cfg_data;
				REG_WAYS:   cfg_q.ways_in_use <= cfg_data;
				default:    cfg_q             <= cfg_q;
			endcase
		end
	end

	// The front splits each address into set and tag and queues the pair.
	sac_front #(
		.MAX_SETS   (MAX_SETS),
		.ADDR_WIDTH (ADDR_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.init_done (init_done),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.q_valid   (q_valid),
		.q_pop     (q_pop),
		.q_set     (q_set),
		.q_tag     (q_tag)
	);

	// The back owns the tag store, the LRU ranks and the MRU way of each set.
	sac_back #(
		.MAX_WAYS   (MAX_WAYS),
		.MAX_SETS   (MAX_SETS),
		.ADDR_WIDTH (ADDR_WIDTH),
		.HALT_BITS  (HALT_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.init_done (init_done),
		.q_valid   (q_valid),
		.q_pop     (q_pop),
		.q_set     (q_set),
		.q_tag     (q_tag),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule
`default_nettype wire

// ----- dv/tb_top.sv -----
`default_nettype none
module tb_top;
	import sac_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned NWAYS = 8;
	localparam int unsigned NSETS = 1024;
	localparam int unsigned NRAND = 500;

	// Input and result words: the stream ports and the packed layout of a result.
	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [CfgIdxW-1:0]  cfg_index;
	logic [CfgDataW-1:0] cfg_data;
	logic                s_tvalid;
	logic                s_tready;
	logic [SDataW-1:0]   s_tdata;   // address[31:0]
	logic                m_tvalid;
	logic                m_tready;
	logic [MDataW-1:0]   m_tdata;   // hit, hit_way[2:0], predicted_hit, ways_probed[3:0],
	                                // set_index[9:0], zero pad

	set_assoc_cache_tag_lru_way_predict_unit dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	// The testbench's own copy of the tag store and of the register file.
	bit            tv_valid [NSETS*NWAYS];
	bit [31:0]     tv_tag   [NSETS*NWAYS];
	bit [2:0]      tv_rank  [NSETS*NWAYS];
	bit [3:0]      tv_halt  [NSETS*NWAYS];
	bit [2:0]      tv_mru   [NSETS];
	bit [1:0]      c_mode;
	bit [3:0]      c_off;
	bit [3:0]      c_sets;
	bit [3:0]      c_ways;

	result_t       lookup_q[$];
	int            errors;
	int            results_seen;
	int            hits_seen;
	int            words_sent;
	bit            long_stall;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("[set_assoc_cache_tag_lru_way_predict_unit] ERROR");
		$finish;
	end

	// Works out the lookup result for one address and updates the copy of the
	// tag store the way the block does: hit or fill, then the LRU touch.
	function automatic result_t predict_lookup(input bit [31:0] addr);
		result_t r;
		int ob, sb, ways, set, base, w, p, q, probed;
		bit [31:0] tag;
		bit [3:0] htag;
		bit hit, pred;
		bit [2:0] old;
		ob = (c_off > 12) ? 12 : c_off;
		sb = (c_sets > 10) ? 10 : c_sets;
		ways = (c_ways == 0) ? 1 : ((c_ways > NWAYS) ? NWAYS : c_ways);
		set = int'((addr >> ob) & ((32'd1 << sb) - 1));
		tag = addr >> (ob + sb);
		htag = tag[3:0];
		base = set * NWAYS;
		hit = 0;
		pred = 0;
		w = 0;
		probed = 0;
		if (c_mode == MODE_PREDICT) begin
			p = tv_mru[set];
			if (p >= ways) p = 0;
			probed = 1;
			if (tv_valid[base+p] && tv_tag[base+p] == tag) begin
				hit = 1; pred = 1; w = p;
			end else begin
				probed = ways;
				for (int i = 1; i < ways && !hit; i++) begin
					q = (p + i) % ways;
					if (tv_valid[base+q] && tv_tag[base+q] == tag) begin
						hit = 1; w = q;
					end
				end
			end
		end else if (c_mode == MODE_HALT) begin
			for (int i = 0; i < ways; i++) begin
				if (tv_halt[base+i] == htag) begin
					probed++;
					if (!hit && tv_valid[base+i] && tv_tag[base+i] == tag) begin
						hit = 1; w = i;
					end
				end
			end
		end else begin
			probed = ways;
			for (int i = 0; i < ways && !hit; i++)
				if (tv_valid[base+i] && tv_tag[base+i] == tag) begin
					hit = 1; w = i;
				end
		end
		if (!hit) begin
			// Victim is the lowest rank, lowest index on a tie.
			w = 0;
			for (int i = 1; i < ways; i++)
				if (tv_rank[base+i] < tv_rank[base+w]) w = i;
			tv_valid[base+w] = 1;
			tv_tag[base+w] = tag;
			tv_halt[base+w] = htag;
		end
		old = tv_rank[base+w];
		for (int i = 0; i < ways; i++)
			if (i != w && tv_rank[base+i] > old) tv_rank[base+i]--;
		tv_rank[base+w] = 3'(ways - 1);
		tv_mru[set] = 3'(w);
		r = '0;
		r.hit = hit;
		r.hit_way = 3'(w);
		r.predicted_hit = pred;
		r.ways_probed = 4'(probed);
		r.set_index = 10'(set);
		return r;
	endfunction

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_MODE:   c_mode = val[1:0];
			REG_OFFSET: c_off = val;
			REG_SETS:   c_sets = val;
			default:    c_ways = val;
		endcase
	endtask

	// Sends one address word after a random gap; the prediction is queued at the
	// accepting edge so it always matches the order the block sees. The valid
	// stays high after the accepting edge until the next word or the next drain.
	task automatic send_word(input bit [31:0] addr);
		int gap;
		gap = (($urandom & 3) == 0) ? 0 : $urandom_range(0, 19);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= addr;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		lookup_q.push_back(predict_lookup(addr));
		words_sent++;
	endtask

	// Waits until every queued result has come back, then lets the back end settle.
	task automatic drain;
		int guard;
		guard = 0;
		s_tvalid <= 1'b0;
		while (lookup_q.size() != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (10) @(posedge clk);
	endtask

	// Result side: random stalls, one long hold-off when asked, and the check.
	initial begin
		result_t got, want;
		int wait_n;
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				got = result_t'(m_tdata);
				if (lookup_q.size() == 0) begin
					$error("result with nothing expected: %h", m_tdata);
					errors++;
				end else begin
					want = lookup_q.pop_front();
					results_seen++;
					if (got.hit) hits_seen++;
					if (got.hit !== want.hit) begin
						$error("hit: expected %0d, got %0d", want.hit, got.hit);
						errors++;
					end
					if (got.hit_way !== want.hit_way) begin
						$error("hit_way: expected %0d, got %0d", want.hit_way, got.hit_way);
						errors++;
					end
					if (got.predicted_hit !== want.predicted_hit) begin
						$error("predicted_hit: expected %0d, got %0d",
							want.predicted_hit, got.predicted_hit);
						errors++;
					end
					if (got.ways_probed !== want.ways_probed) begin
						$error("ways_probed: expected %0d, got %0d",
							want.ways_probed, got.ways_probed);
						errors++;
					end
					if (got.set_index !== want.set_index) begin
						$error("set_index: expected %0d, got %0d",
							want.set_index, got.set_index);
						errors++;
					end
					if (got.pad !== '0) begin
						$error("pad: expected 0, got %h", got.pad);
						errors++;
					end
				end
			end
			if (long_stall) begin
				m_tready <= 1'b0;
				repeat (300) @(posedge clk);
				long_stall = 0;
				m_tready <= 1'b1;
			end else begin
				wait_n = (($urandom & 3) == 0) ? 0 : $urandom_range(0, 19);
				if (wait_n == 0) m_tready <= 1'b1;
				else begin
					m_tready <= 1'b0;
					repeat (wait_n) @(posedge clk);
					m_tready <= 1'b1;
				end
			end
		end
	end

	// A directed row: address, and where obvious the expected hit flag.
	typedef struct {
		bit [31:0] addr;
		bit        check_hit;
		bit        want_hit;
	} stim_row_t;

	// Addresses for the random part are drawn from a small pool of tags per set
	// so that hits, evictions and halt-tag clashes all happen often.
	function automatic bit [31:0] pick_addr();
		bit [31:0] a;
		int ob, sb;
		ob = (c_off > 12) ? 12 : c_off;
		sb = (c_sets > 10) ? 10 : c_sets;
		if (($urandom & 7) == 0) return $urandom;
		a = $urandom & ((32'd1 << ob) - 1);
		a |= ($urandom_range(0, 7) << ob) & ((32'd1 << (ob + sb)) - 1);
		// Tags differ in either the low four bits or only in upper bits.
		a |= (($urandom_range(0, 11) | ((($urandom & 1) ? 32'h10 : 32'h0))) << (ob + sb));
		if (($urandom & 15) == 0) a |= 32'h8000_0000;
		return a;
	endfunction

	initial begin
		stim_row_t rows[$];
		bit [3:0] cfgs[8][4];
		int idx;
		errors = 0;
		results_seen = 0;
		hits_seen = 0;
		words_sent = 0;
		long_stall = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		c_mode = MODE_CONV;
		c_off = 4'd6;
		c_sets = 4'd6;
		c_ways = 4'd4;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: reset settings first. A cold access misses and fills way 0,
		// the same address then hits; address extremes included.
		rows = '{
			'{32'h0000_0000, 1, 0}, '{32'h0000_0000, 1, 1}, '{32'hFFFF_FFFF, 1, 0},
			'{32'hFFFF_FFFF, 1, 1}, '{32'h0000_003F, 1, 1}, '{32'h0000_1000, 1, 0},
			'{32'h0000_2000, 1, 0}, '{32'h0000_3000, 1, 0}, '{32'h0000_4000, 1, 0},
			'{32'h0000_0000, 1, 0}, '{32'hAAAA_AAAA, 1, 0}, '{32'h5555_5555, 1, 0}
		};
		foreach (rows[i]) begin
			send_word(rows[i].addr);
			if (rows[i].check_hit && lookup_q[$].hit !== rows[i].want_hit) begin
				$error("directed row %0d: table says hit %0d", i, rows[i].want_hit);
				errors++;
			end
		end
		drain();

		// Way prediction and way halting with all ways, then mode 3, which acts as conventional, with one way.
		// In halting mode, tags 0x01 and 0x41 share a halt tag while 0x02 does not.
		write_reg(REG_MODE, MODE_PREDICT);
		write_reg(REG_WAYS, 4'd8);
		foreach (rows[i]) send_word(rows[i].addr);
		send_word(32'h0000_4000);
		drain();
		write_reg(REG_WAYS, 4'd15);
		send_word(32'h0000_4000);
		drain();
		write_reg(REG_MODE, MODE_HALT);
		send_word(32'h0000_1000);
		send_word(32'h0004_1000);
		send_word(32'h0000_2000);
		send_word(32'h0000_1000);
		drain();
		write_reg(REG_MODE, 4'd3);
		write_reg(REG_WAYS, 4'd0);
		send_word(32'h0000_1000);
		drain();

		// Random phases, each with its own settings, extremes among them.
		cfgs = '{
			'{4'd0, 4'd6, 4'd6, 4'd4}, '{4'd1, 4'd0, 4'd0, 4'd8},
			'{4'd2, 4'd12, 4'd10, 4'd8}, '{4'd1, 4'd15, 4'd15, 4'd1},
			'{4'd2, 4'd4, 4'd2, 4'd3}, '{4'd3, 4'd2, 4'd3, 4'd15},
			'{4'd0, 4'd12, 4'd10, 4'd0}, '{4'd1, 4'd5, 4'd4, 4'd5}
		};
		for (int ph = 0; ph < 8; ph++) begin
			write_reg(REG_MODE, cfgs[ph][0]);
			write_reg(REG_OFFSET, cfgs[ph][1]);
			write_reg(REG_SETS, cfgs[ph][2]);
			write_reg(REG_WAYS, cfgs[ph][3]);
			if (ph == 2) long_stall = 1;
			for (int n = 0; n < NRAND / 8; n++) begin
				if (ph == 2 && n < 20) begin
					// Back-to-back words during the long hold-off fill the queue.
					s_tvalid <= 1'b1;
					s_tdata <= pick_addr();
					@(posedge clk);
					while (!s_tready) @(posedge clk);
					lookup_q.push_back(predict_lookup(s_tdata));
					words_sent++;
				end else
					send_word(pick_addr());
			end
			drain();
		end

		$display("Sent %0d addresses through the directed table and 8 random phases;",
			words_sent);
		$display("%0d results checked, %0d of them hits.", results_seen, hits_seen);
		if (errors == 0 && lookup_q.size() == 0)
			$display("[set_assoc_cache_tag_lru_way_predict_unit] OK");
		else
			$display("[set_assoc_cache_tag_lru_way_predict_unit] ERROR");
		$finish;
	end
endmodule
`default_nettype wire
